// ===== sv/rbq_pkg.sv =====
`default_nettype none

package rbq_pkg;

    // Operation codes carried by the op field of an input item.
    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_PEEK = 2'd2,
        OP_DROP = 2'd3
    } op_t;

    // Write and read strobes from the pointer logic to the slot memory.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

    // Per-item result flags from the pointer logic to the result register.
    typedef struct packed {
        logic ok;
        logic sel_data;
    } res_flags_t;

endpackage

`default_nettype wire

// ===== sv/rbq_mem.sv =====
`default_nettype none

module rbq_mem
    import rbq_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int ELEM_WIDTH = 32,
    parameter int AW         = 6
) (
    input  wire logic                  aclk,
    input  wire mem_ctl_t              mem_ctl,
    input  wire logic [AW-1:0]         wr_addr,
    input  wire logic [ELEM_WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]         rd_addr,
    output logic      [ELEM_WIDTH-1:0] rd_data
);

    logic [ELEM_WIDTH-1:0] slot_mem [DEPTH];
    logic [ELEM_WIDTH-1:0] rd_data_reg;

    // Slots are never cleared; only entries that hold stored elements are read.
    always_ff @(posedge aclk) begin
        if (mem_ctl.wr_en) begin
            slot_mem[wr_addr] <= wr_data;
        end
        if (mem_ctl.rd_en) begin
            rd_data_reg <= slot_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== sv/rbq_ctrl.sv =====
`default_nettype none

module rbq_ctrl
    import rbq_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int CNT_W = 7
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_we,
    input  wire logic [CNT_W-1:0] cfg_data,
    input  wire logic             item_fire,
    input  wire op_t              op,
    input  wire logic [CNT_W-1:0] amount,
    output mem_ctl_t              mem_ctl,
    output logic      [AW-1:0]    wr_addr,
    output logic      [AW-1:0]    rd_addr,
    output res_flags_t            res_flags,
    output logic      [CNT_W-1:0] res_run,
    output logic      [CNT_W-1:0] res_fill
);

    localparam int SW = CNT_W + 1;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    logic [AW-1:0]    head_reg, head_next;
    logic [AW-1:0]    tail_reg, tail_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] cap_reg,  cap_next;

    logic [CNT_W-1:0] head_p1, tail_p1;
    logic [SW-1:0]    pos_sum, drop_sum;
    logic [CNT_W-1:0] peek_left, to_wrap, drop_n;
    logic [AW-1:0]    peek_addr;
    logic             can_push, can_pop, can_peek;

    always_comb begin
        head_p1   = CNT_W'(head_reg) + CNT_W'(1);
        tail_p1   = CNT_W'(tail_reg) + CNT_W'(1);
        can_push  = fill_reg < cap_reg;
        can_pop   = fill_reg != '0;
        can_peek  = amount < fill_reg;

        // Peek position; the run stops at the wrap point or the last entry.
        pos_sum   = SW'(head_reg) + SW'(amount);
        peek_left = fill_reg - amount;
        to_wrap   = cap_reg - pos_sum[CNT_W-1:0];
        if (pos_sum < SW'(cap_reg)) begin
            peek_addr = pos_sum[AW-1:0];
        end else begin
            peek_addr = AW'(pos_sum - SW'(cap_reg));
        end

        // Drop is clamped to the fill.
        drop_n   = (amount < fill_reg) ? amount : fill_reg;
        drop_sum = SW'(head_reg) + SW'(drop_n);

        head_next       = head_reg;
        tail_next       = tail_reg;
        fill_next       = fill_reg;
        cap_next        = cap_reg;
        mem_ctl         = '0;
        res_flags       = '0;
        res_run         = '0;
        wr_addr         = tail_reg;
        rd_addr         = head_reg;

        if (cfg_we) begin
            if (cfg_data == '0) begin
                cap_next = CNT_W'(1);
            end else if (cfg_data > DEPTH_C) begin
                cap_next = DEPTH_C;
            end else begin
                cap_next = cfg_data;
            end
            head_next = '0;
            tail_next = '0;
            fill_next = '0;
        end else if (item_fire) begin
            case (op)
                OP_PUSH: begin
                    if (can_push) begin
                        mem_ctl.wr_en = 1'b1;
                        tail_next     = (tail_p1 >= cap_reg) ? '0 : tail_p1[AW-1:0];
                        fill_next     = fill_reg + CNT_W'(1);
                        res_flags.ok  = 1'b1;
                    end
                end
                OP_POP: begin
                    if (can_pop) begin
                        mem_ctl.rd_en      = 1'b1;
                        head_next          = (head_p1 >= cap_reg) ? '0 : head_p1[AW-1:0];
                        fill_next          = fill_reg - CNT_W'(1);
                        res_flags.ok       = 1'b1;
                        res_flags.sel_data = 1'b1;
                    end
                end
                OP_PEEK: begin
                    if (can_peek) begin
                        mem_ctl.rd_en      = 1'b1;
                        rd_addr            = peek_addr;
                        res_flags.ok       = 1'b1;
                        res_flags.sel_data = 1'b1;
                        if (pos_sum < SW'(cap_reg)) begin
                            res_run = (to_wrap < peek_left) ? to_wrap : peek_left;
                        end else begin
                            res_run = peek_left;
                        end
                    end
                end
                OP_DROP: begin
                    if (drop_sum >= SW'(cap_reg)) begin
                        head_next = AW'(drop_sum - SW'(cap_reg));
                    end else begin
                        head_next = drop_sum[AW-1:0];
                    end
                    fill_next    = fill_reg - drop_n;
                    res_run      = drop_n;
                    res_flags.ok = 1'b1;
                end
                default: begin
                    res_flags = '0;
                end
            endcase
        end
        res_fill = fill_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
            fill_reg <= '0;
            cap_reg  <= DEPTH_C;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            fill_reg <= fill_next;
            cap_reg  <= cap_next;
        end
    end

    logic [SW-1:0] tail_calc;
    assign tail_calc = SW'(head_reg) + SW'(fill_reg);

    a_fill_le_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= cap_reg)
        else $error("fill exceeds capacity");

    a_head_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (CNT_W'(head_reg) < cap_reg) && (CNT_W'(tail_reg) < cap_reg))
        else $error("head or tail beyond capacity");

    a_tail_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        ((tail_calc >= SW'(cap_reg)) ? (tail_calc - SW'(cap_reg)) : tail_calc)
            == SW'(tail_reg))
        else $error("tail does not match head plus fill");

    a_cfg_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> (fill_reg == '0) && (head_reg == '0) && (tail_reg == '0))
        else $error("capacity write did not empty the queue");

endmodule

`default_nettype wire

// ===== sv/ring_buffer_queue.sv =====
`default_nettype none

// Channel   | Direction | Handshake              | Payload
// ----------+-----------+------------------------+----------------------------------
// s_        | in        | s_valid / s_ready      | s_op, s_data_in, s_amount
// m_        | out       | m_valid / m_ready      | m_ok, m_data_out, m_run_length, m_fill
// cfg_      | in        | cfg_valid / cfg_ready  | cfg_data (capacity)
//
// One item can be accepted every cycle; its result is presented in the cycle after
// the transfer, set by the registered read port of the slot memory.
// The input stalls only while a result waits in the register with m_ready low, or cfg_valid is high.
// Reset (aresetn low at a clock edge) empties the queue and sets capacity to DEPTH;
// slot contents are not cleared, since only stored entries are ever read.
// A capacity write is taken at once, empties the queue and holds off s_ready that cycle.

module ring_buffer_queue
    import rbq_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int ELEM_WIDTH = 32
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,

    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [$clog2(DEPTH+1)-1:0]           cfg_data,

    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic [1:0]                           s_op,
    input  wire logic [ELEM_WIDTH-1:0]                s_data_in,
    input  wire logic [$clog2(DEPTH+1)-1:0]           s_amount,

    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic                                      m_ok,
    output logic      [ELEM_WIDTH-1:0]                m_data_out,
    output logic      [$clog2(DEPTH+1)-1:0]           m_run_length,
    output logic      [$clog2(DEPTH+1)-1:0]           m_fill
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH+1);

    logic                  item_fire;
    logic                  cfg_we;
    mem_ctl_t              mem_ctl;
    logic [AW-1:0]         wr_addr;
    logic [AW-1:0]         rd_addr;
    logic [ELEM_WIDTH-1:0] rd_data;
    res_flags_t            res_flags;
    logic [CNT_W-1:0]      res_run;
    logic [CNT_W-1:0]      res_fill;

    // Result register: valid is control state, the rest is payload.
    logic             m_valid_reg, m_valid_next;
    logic             ok_reg;
    logic             sel_data_reg;
    logic [CNT_W-1:0] run_reg;
    logic [CNT_W-1:0] fill_reg;

    // The register can take a new result when it is empty or drains this cycle.
    // A capacity write has priority, so no item is taken in the same cycle.
    assign s_ready   = (!m_valid_reg || m_ready) && !cfg_valid;
    assign item_fire = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid;

    rbq_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CNT_W (CNT_W)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .item_fire (item_fire),
        .op        (op_t'(s_op)),
        .amount    (s_amount),
        .mem_ctl   (mem_ctl),
        .wr_addr   (wr_addr),
        .rd_addr   (rd_addr),
        .res_flags (res_flags),
        .res_run   (res_run),
        .res_fill  (res_fill)
    );

    // The memory read lands in its own output register at the same edge that
    // loads the rest of the result, so both line up in the next cycle.
    rbq_mem #(
        .DEPTH      (DEPTH),
        .ELEM_WIDTH (ELEM_WIDTH),
        .AW         (AW)
    ) u_mem (
        .aclk    (aclk),
        .mem_ctl (mem_ctl),
        .wr_addr (wr_addr),
        .wr_data (s_data_in),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (item_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_fire) begin
            ok_reg       <= res_flags.ok;
            sel_data_reg <= res_flags.sel_data;
            run_reg      <= res_run;
            fill_reg     <= res_fill;
        end
    end

    // Data out is zero unless a pop or peek succeeded; the memory output
    // register holds stale data otherwise.
    assign m_valid      = m_valid_reg;
    assign m_ok         = ok_reg;
    assign m_data_out   = sel_data_reg ? rd_data : '0;
    assign m_run_length = run_reg;
    assign m_fill       = fill_reg;

endmodule

`default_nettype wire

// ===== tb/ring_buffer_queue_checker.sv =====
`timescale 1ns / 1ps

// Watches the configuration, item and result channels of the ring buffer queue,
// keeps its own copy of the queue state, and compares every result transfer
// against the oldest outstanding prediction.
module ring_buffer_queue_checker
    import rbq_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int ELEM_WIDTH = 32
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,

    input  wire logic                        cfg_valid,
    input  wire logic                        cfg_ready,
    input  wire logic [$clog2(DEPTH+1)-1:0]  cfg_data,

    input  wire logic                        s_valid,
    input  wire logic                        s_ready,
    input  wire logic [1:0]                  s_op,
    input  wire logic [ELEM_WIDTH-1:0]       s_data_in,
    input  wire logic [$clog2(DEPTH+1)-1:0]  s_amount,

    input  wire logic                        m_valid,
    input  wire logic                        m_ready,
    input  wire logic                        m_ok,
    input  wire logic [ELEM_WIDTH-1:0]       m_data_out,
    input  wire logic [$clog2(DEPTH+1)-1:0]  m_run_length,
    input  wire logic [$clog2(DEPTH+1)-1:0]  m_fill,

    output int                               fail_count,
    output int                               pending
);

    localparam int CW = $clog2(DEPTH+1);

    typedef struct packed {
        logic                  ok;
        logic [ELEM_WIDTH-1:0] data;
        logic [CW-1:0]         run;
        logic [CW-1:0]         fill;
    } queue_result_t;

    queue_result_t         expected_results[$];
    logic [ELEM_WIDTH-1:0] slot_copy[DEPTH];
    int                    head_pos;
    int                    tail_pos;
    int                    fill_level;
    int                    slots_in_use;
    int                    errors = 0;

    function automatic int next_pos(int p);
        return (p + 1 >= slots_in_use) ? 0 : p + 1;
    endfunction

    // Applies one operation to the shadow queue and returns the result it must produce.
    function automatic queue_result_t apply_queue_op(op_t op, logic [ELEM_WIDTH-1:0] din,
                                                     int amt);
        queue_result_t r;
        int            pos;
        int            left;
        int            n;
        r = '0;
        case (op)
            OP_PUSH: begin
                if (fill_level < slots_in_use) begin
                    slot_copy[tail_pos] = din;
                    tail_pos = next_pos(tail_pos);
                    fill_level++;
                    r.ok = 1'b1;
                end
            end
            OP_POP: begin
                if (fill_level > 0) begin
                    r.data = slot_copy[head_pos];
                    head_pos = next_pos(head_pos);
                    fill_level--;
                    r.ok = 1'b1;
                end
            end
            OP_PEEK: begin
                if (amt < fill_level) begin
                    pos  = head_pos + amt;
                    left = fill_level - amt;
                    if (pos < slots_in_use) begin
                        n = slots_in_use - pos;
                        r.run = CW'((n < left) ? n : left);
                    end else begin
                        pos -= slots_in_use;
                        r.run = CW'(left);
                    end
                    r.data = slot_copy[pos];
                    r.ok   = 1'b1;
                end
            end
            default: begin
                n = (amt < fill_level) ? amt : fill_level;
                head_pos += n;
                if (head_pos >= slots_in_use) begin
                    head_pos -= slots_in_use;
                end
                fill_level -= n;
                r.run = CW'(n);
                r.ok  = 1'b1;
            end
        endcase
        r.fill = CW'(fill_level);
        return r;
    endfunction

    function automatic void check_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        queue_result_t want;
        if (!aresetn) begin
            expected_results.delete();
            head_pos     = 0;
            tail_pos     = 0;
            fill_level   = 0;
            slots_in_use = DEPTH;
        end else begin
            // A result leaves at the earliest in the cycle after its item, so the
            // comparison goes first and the new prediction is queued after it.
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with no outstanding item");
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("ok", want.ok, m_ok);
                    check_field("data_out", want.data, m_data_out);
                    check_field("run_length", want.run, m_run_length);
                    check_field("fill", want.fill, m_fill);
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_data == 0) begin
                    slots_in_use = 1;
                end else if (cfg_data > DEPTH) begin
                    slots_in_use = DEPTH;
                end else begin
                    slots_in_use = cfg_data;
                end
                head_pos   = 0;
                tail_pos   = 0;
                fill_level = 0;
            end
            if (s_valid && s_ready) begin
                expected_results.push_back(apply_queue_op(op_t'(s_op), s_data_in, s_amount));
            end
        end
        pending    <= expected_results.size();
        fail_count <= errors;
    end

endmodule

// ===== tb/ring_buffer_queue_tb.sv =====
`timescale 1ns / 1ps

// Top of the ring buffer queue testbench. It makes the clock and reset, drives
// the configuration and item channels, throttles the result channel, and gives
// the verdict. All prediction and comparison live in the checker instance.
module ring_buffer_queue_tb;
    import rbq_pkg::*;

    localparam int DEPTH       = 64;
    localparam int ELEM_WIDTH  = 32;
    localparam int CW          = $clog2(DEPTH+1);
    localparam int IDLE_PCT    = 35;
    localparam int HOLD_CYCLES = 150;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;

    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CW-1:0]         cfg_data = '0;

    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [1:0]            s_op = OP_PUSH;
    logic [ELEM_WIDTH-1:0] s_data_in = '0;
    logic [CW-1:0]         s_amount = '0;

    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic                  m_ok;
    logic [ELEM_WIDTH-1:0] m_data_out;
    logic [CW-1:0]         m_run_length;
    logic [CW-1:0]         m_fill;

    int                    fail_count;
    int                    pending;

    // When set, neither the sender nor the receiver inserts idle cycles.
    bit                    no_idle = 1'b0;
    // The stimulus bumps hold_requests to ask the receiver for one long hold-off.
    int                    hold_requests = 0;
    int                    holds_done = 0;

    ring_buffer_queue #(
        .DEPTH     (DEPTH),
        .ELEM_WIDTH(ELEM_WIDTH)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .s_data_in   (s_data_in),
        .s_amount    (s_amount),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_ok        (m_ok),
        .m_data_out  (m_data_out),
        .m_run_length(m_run_length),
        .m_fill      (m_fill)
    );

    ring_buffer_queue_checker #(
        .DEPTH     (DEPTH),
        .ELEM_WIDTH(ELEM_WIDTH)
    ) queue_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .s_data_in   (s_data_in),
        .s_amount    (s_amount),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_ok        (m_ok),
        .m_data_out  (m_data_out),
        .m_run_length(m_run_length),
        .m_fill      (m_fill),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    initial begin
        forever begin
            #4 aclk = ~aclk;
        end
    end

    // The whole run takes well under a tenth of this even with every item
    // stalled by both sides; reaching it means the block has hung.
    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Result side. Normally ready is dropped at random in about a third of the
    // cycles. A hold-off request keeps ready low for a long, fixed stretch that
    // this process counts on its own, so the output register stays full and
    // the item channel has to stall behind it.
    initial begin
        forever begin
            @(posedge aclk);
            if (holds_done != hold_requests) begin
                holds_done++;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Offers one item and returns at the edge where the transfer happens.
    // Valid is left high on return; the next call either keeps it high for a
    // back-to-back transfer or lowers it for some idle cycles first, so valid
    // never sees two assignments in one time step.
    task automatic send_item(op_t op, logic [ELEM_WIDTH-1:0] din, int amt);
        if (!no_idle) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid   <= 1'b1;
        s_op      <= op;
        s_data_in <= din;
        s_amount  <= CW'(amt);
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stops offering items and waits until every predicted result has come back.
    // Each item yields one result, so the block counts as idle once no
    // prediction is still pending.
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_capacity(int value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= CW'(value);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // A burst of random operations. push_pct biases the mix toward filling or
    // toward draining; span is the capacity in effect, so peek offsets mostly
    // fall where stored entries can be and sometimes past them.
    task automatic random_burst(int count, int push_pct, int span);
        int pick;
        int amt;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < push_pct) begin
                send_item(OP_PUSH, $urandom(), $urandom_range(DEPTH));
            end else begin
                case ($urandom_range(2))
                    0: send_item(OP_POP, $urandom(), $urandom_range(DEPTH));
                    1: begin
                        amt = ($urandom_range(9) == 0) ? $urandom_range(DEPTH)
                                                       : $urandom_range(span);
                        send_item(OP_PEEK, $urandom(), amt);
                    end
                    default: begin
                        amt = ($urandom_range(7) == 0) ? $urandom_range(DEPTH)
                                                       : $urandom_range(3);
                        send_item(OP_DROP, $urandom(), amt);
                    end
                endcase
            end
        end
    endtask

    initial begin
        int phase_cap[7];
        int phase_span[7];

        phase_cap  = '{1, 2, 5, 64, 17, 0, 33};
        phase_span = '{1, 2, 5, 64, 17, 1, 33};

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty queue at the reset capacity: every read-type operation is
        // refused or removes nothing.
        send_item(OP_POP, 32'h0, 0);
        send_item(OP_PEEK, 32'h0, 0);
        send_item(OP_DROP, 32'h0, 5);

        // Extreme data patterns, then peeks inside and beyond the fill,
        // including the largest offset.
        send_item(OP_PUSH, 32'h0000_0000, 0);
        send_item(OP_PUSH, 32'hFFFF_FFFF, DEPTH);
        send_item(OP_PUSH, 32'hA5A5_A5A5, 0);
        send_item(OP_PUSH, 32'h5A5A_5A5A, 0);
        send_item(OP_PEEK, 32'h0, 0);
        send_item(OP_PEEK, 32'h0, 3);
        send_item(OP_PEEK, 32'h0, 4);
        send_item(OP_PEEK, 32'h0, DEPTH);
        send_item(OP_POP, 32'h0, 0);
        send_item(OP_DROP, 32'h0, 1);
        // The drop count exceeds the fill and gets clamped.
        send_item(OP_DROP, 32'h0, DEPTH);
        send_item(OP_POP, 32'h0, 0);

        // A zero capacity is taken as a single slot: the second push is refused.
        write_capacity(0);
        send_item(OP_PUSH, 32'h1234_5678, 0);
        send_item(OP_PUSH, 32'h8765_4321, 0);
        send_item(OP_PEEK, 32'h0, 0);
        send_item(OP_POP, 32'h0, 0);

        // Three slots with the tail wrapped: one peek sees a run cut by the
        // wrap point, the other lands past it.
        write_capacity(3);
        send_item(OP_PUSH, 32'h0000_0011, 0);
        send_item(OP_PUSH, 32'h0000_0022, 0);
        send_item(OP_PUSH, 32'h0000_0033, 0);
        send_item(OP_POP, 32'h0, 0);
        send_item(OP_PUSH, 32'h0000_0044, 0);
        send_item(OP_PEEK, 32'h0, 0);
        send_item(OP_PEEK, 32'h0, 2);

        // Backpressure: a capacity above the depth is clamped to the full
        // depth, and the sender pushes past full while the receiver is held
        // off, so the block stalls its input behind the waiting result.
        write_capacity(127);
        no_idle = 1'b1;
        hold_requests++;
        for (int i = 0; i < DEPTH + 6; i++) begin
            send_item(OP_PUSH, $urandom(), 0);
        end
        no_idle = 1'b0;

        // Random phases over a spread of capacities, each first filling and
        // then draining so head and tail wrap many times. One phase runs with
        // no idle cycles on either side.
        foreach (phase_cap[p]) begin
            write_capacity(phase_cap[p]);
            no_idle = (p == 4);
            random_burst(40, 70, phase_span[p]);
            random_burst(40, 25, phase_span[p]);
        end
        no_idle = 1'b0;

        drain_results();
        repeat (10) @(posedge aclk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
